/* hdl/vna_pkg.sv */
package vna_pkg;

  localparam int VertexDepthDefault = 8192;

  localparam int CmdW    = 2;
  localparam int CornerW = 13;
  localparam int PosW    = 24;
  localparam int SumW    = 20;
  localparam int StatW   = 2;

  localparam logic [CmdW-1:0] CmdWrite    = 2'd0;
  localparam logic [CmdW-1:0] CmdTriangle = 2'd1;
  localparam logic [CmdW-1:0] CmdRead     = 2'd2;
  localparam logic [CmdW-1:0] CmdUnused   = 2'd3;

  localparam logic [StatW-1:0] StOk         = 2'd0;
  localparam logic [StatW-1:0] StDegenerate = 2'd1;
  localparam logic [StatW-1:0] StSaturated  = 2'd2;

endpackage

/* hdl/vna_in_if.sv */
interface vna_in_if;
  logic                             valid;
  logic                             ready;
  logic        [vna_pkg::CmdW-1:0]    command;
  logic        [vna_pkg::CornerW-1:0] corner_a;
  logic        [vna_pkg::CornerW-1:0] corner_b;
  logic        [vna_pkg::CornerW-1:0] corner_c;
  logic signed [vna_pkg::PosW-1:0]    pos_x;
  logic signed [vna_pkg::PosW-1:0]    pos_y;
  logic signed [vna_pkg::PosW-1:0]    pos_z;

  modport source (output valid, command, corner_a, corner_b, corner_c, pos_x, pos_y, pos_z,
                  input ready);
  modport sink   (input valid, command, corner_a, corner_b, corner_c, pos_x, pos_y, pos_z,
                  output ready);
endinterface

/* hdl/vna_out_if.sv */
interface vna_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [vna_pkg::SumW-1:0]  sum_x;
  logic signed [vna_pkg::SumW-1:0]  sum_y;
  logic signed [vna_pkg::SumW-1:0]  sum_z;
  logic        [vna_pkg::StatW-1:0] status;

  modport source (output valid, sum_x, sum_y, sum_z, status, input ready);
  modport sink   (input valid, sum_x, sum_y, sum_z, status, output ready);
endinterface

/* hdl/vna_ram.sv */
module vna_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

/* hdl/vertex_normal_accumulator.sv */
// Vertex store with per-vertex normal sums. Positions and sums sit in two single-port
// memories of VERTEX_DEPTH entries; corner indices are reduced modulo VERTEX_DEPTH by a
// reciprocal multiply and a subtract. A triangle takes three position reads, six
// cross-product multiplies on one multiplier, a one-bit-a-cycle normalizing shift, three
// squares, a bit-serial square root, a divider per component and three read-modify-write
// passes on the sum memory. A degenerate triangle ends after the cross product. Any item
// is held at its end while the output register is stalled. Only one item is in work at
// a time; a finished result waits in the output register while the next item is
// accepted. Never-written entries read back as undefined.
module vertex_normal_accumulator #(
  parameter int VERTEX_DEPTH = vna_pkg::VertexDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vna_in_if.sink    in_i,
  vna_out_if.source out_o
);

  localparam int AW  = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int CW  = vna_pkg::CornerW;
  localparam int QSH = CW + AW;
  localparam int RW  = CW + 2;
  localparam int PW  = CW + RW;
  localparam int MW  = CW + 17;
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << QSH) + 64'(VERTEX_DEPTH) - 64'd1) / 64'(VERTEX_DEPTH));

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MOD  = 5'd1;
  localparam logic [4:0] S_DISP = 5'd2;
  localparam logic [4:0] S_SRD  = 5'd3;
  localparam logic [4:0] S_PRD  = 5'd4;
  localparam logic [4:0] S_EDGE = 5'd5;
  localparam logic [4:0] S_XMUL = 5'd6;
  localparam logic [4:0] S_XACC = 5'd7;
  localparam logic [4:0] S_ABS  = 5'd8;
  localparam logic [4:0] S_NORM = 5'd9;
  localparam logic [4:0] S_SQM  = 5'd10;
  localparam logic [4:0] S_SQA  = 5'd11;
  localparam logic [4:0] S_ROOT = 5'd12;
  localparam logic [4:0] S_DIVI = 5'd13;
  localparam logic [4:0] S_DIVS = 5'd14;
  localparam logic [4:0] S_URD  = 5'd15;
  localparam logic [4:0] S_UWR  = 5'd16;
  localparam logic [4:0] S_DONE = 5'd17;
  localparam logic [4:0] S_MODR = 5'd18;

  logic [4:0] state_q;
  logic [5:0] cnt_q;
  logic [1:0] sel_q;
  logic       ovalid_q;

  logic [vna_pkg::CmdW-1:0] cmd_q;
  logic [CW-1:0]            raw_q [3];
  logic [CW-1:0]            quot_q [3];
  logic [AW-1:0]            idx   [3];
  logic [PW-1:0]            rprod [3];
  logic [71:0]              pos_q [3];
  logic signed [24:0]       e1_q [3];
  logic signed [24:0]       e2_q [3];
  logic signed [49:0]       prod_q;
  logic signed [50:0]       cr_q [3];
  logic [50:0]              mag_q [3];
  logic                     neg_q [3];
  logic [59:0]              sqp_q;
  logic [61:0]              sq_q;
  logic [61:0]              n_q;
  logic [62:0]              res_q;
  logic [46:0]              rem_q;
  logic [14:0]              quo_q;
  logic signed [15:0]       nrm_q [3];

  logic signed [vna_pkg::SumW-1:0]  rx_q, ry_q, rz_q;
  logic [vna_pkg::StatW-1:0]        rst_q;
  logic signed [vna_pkg::SumW-1:0]  ox_q, oy_q, oz_q;
  logic [vna_pkg::StatW-1:0]        ost_q;

  logic          pos_we, sum_we;
  logic [AW-1:0] pos_addr, sum_addr;
  logic [71:0]   pos_wdata, pos_rdata;
  logic [59:0]   sum_wdata, sum_rdata;

  logic          in_acc, out_free;
  logic [AW-1:0] idx_cnt, idx_sel;
  logic signed [24:0] opa, opb;
  logic          any_high, all_low;
  logic [63:0]   rbit, rtst;
  logic [46:0]   dsub;
  logic          dtake;
  logic [14:0]   quo_nx;
  logic signed [vna_pkg::SumW-1:0] upd [3];
  logic          upd_sat [3];

  for (genvar k = 0; k < 3; k++) begin : g_idx
    assign idx[k]   = AW'(raw_q[k]);
    assign rprod[k] = PW'(raw_q[k]) * PW'(RECIP);
  end

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !ovalid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    case (cnt_q[1:0])
      2'd1:    idx_cnt = idx[1];
      2'd2:    idx_cnt = idx[2];
      default: idx_cnt = idx[0];
    endcase
    case (sel_q)
      2'd1:    idx_sel = idx[1];
      2'd2:    idx_sel = idx[2];
      default: idx_sel = idx[0];
    endcase
  end

  // cross product operands, one product per step
  always_comb begin
    case (cnt_q[2:0])
      3'd0:    begin opa = e1_q[1]; opb = e2_q[2]; end
      3'd1:    begin opa = e2_q[1]; opb = e1_q[2]; end
      3'd2:    begin opa = e2_q[0]; opb = e1_q[2]; end
      3'd3:    begin opa = e1_q[0]; opb = e2_q[2]; end
      3'd4:    begin opa = e1_q[0]; opb = e2_q[1]; end
      default: begin opa = e2_q[0]; opb = e1_q[1]; end
    endcase
  end

  always_comb begin
    any_high = 1'b0;
    all_low  = 1'b1;
    for (int k = 0; k < 3; k++) begin
      any_high = any_high | (|mag_q[k][50:30]);
      all_low  = all_low & ~(|mag_q[k][50:29]);
    end
  end

  assign rbit = 64'(1) << (6'd62 - {cnt_q[4:0], 1'b0});
  assign rtst = {1'b0, res_q} + rbit;

  assign dsub   = 47'(res_q[31:0]) << cnt_q[3:0];
  assign dtake  = (rem_q >= dsub);
  assign quo_nx = quo_q | (dtake ? (15'(1) << cnt_q[3:0]) : 15'd0);

  // saturating add of the normal onto the stored sum
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [20:0] s;
      s = 21'(signed'(sum_rdata[20*k +: 20])) + 21'(nrm_q[k]);
      upd_sat[k] = 1'b0;
      if (s > 21'sd524287) begin
        upd[k] = 20'sd524287;
        upd_sat[k] = 1'b1;
      end else if (s < -21'sd524288) begin
        upd[k] = -20'sd524288;
        upd_sat[k] = 1'b1;
      end else begin
        upd[k] = s[19:0];
      end
    end
  end

  always_comb begin
    pos_we    = 1'b0;
    pos_addr  = idx[0];
    pos_wdata = {pos_q[0][71:0]};
    sum_we    = 1'b0;
    sum_addr  = idx[0];
    sum_wdata = {upd[2], upd[1], upd[0]};
    case (state_q)
      S_DISP: begin
        pos_we    = (cmd_q == vna_pkg::CmdWrite);
        sum_we    = (cmd_q == vna_pkg::CmdWrite);
        pos_wdata = pos_q[0];
        sum_wdata = '0;
      end
      S_PRD: pos_addr = idx_cnt;
      S_URD: sum_addr = idx_sel;
      S_UWR: begin
        sum_addr = idx_sel;
        sum_we   = 1'b1;
      end
      default: ;
    endcase
  end

  vna_ram #(.Width(72), .Depth(VERTEX_DEPTH)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .addr_i  (pos_addr),
    .wdata_i (pos_wdata),
    .rdata_o (pos_rdata)
  );

  vna_ram #(.Width(60), .Depth(VERTEX_DEPTH)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .addr_i  (sum_addr),
    .wdata_i (sum_wdata),
    .rdata_o (sum_rdata)
  );

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      sel_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if ((state_q == S_DONE) && out_free) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_MOD;
          end
        end
        S_MOD:  state_q <= S_MODR;
        S_MODR: state_q <= S_DISP;
        S_DISP: begin
          cnt_q <= '0;
          case (cmd_q)
            vna_pkg::CmdTriangle: state_q <= S_PRD;
            vna_pkg::CmdRead:     state_q <= S_SRD;
            default:              state_q <= S_DONE;
          endcase
        end
        S_SRD: state_q <= S_DONE;
        S_PRD: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd3) begin
            state_q <= S_EDGE;
          end
        end
        S_EDGE: begin
          cnt_q   <= '0;
          state_q <= S_XMUL;
        end
        S_XMUL: state_q <= S_XACC;
        S_XACC: begin
          cnt_q   <= cnt_q + 6'd1;
          state_q <= (cnt_q == 6'd5) ? S_ABS : S_XMUL;
        end
        S_ABS: begin
          state_q <= ((cr_q[0] == '0) && (cr_q[1] == '0) && (cr_q[2] == '0)) ? S_DONE : S_NORM;
        end
        S_NORM: begin
          if (!any_high && !all_low) begin
            state_q <= S_SQM;
            sel_q   <= '0;
          end
        end
        S_SQM: state_q <= S_SQA;
        S_SQA: begin
          sel_q <= sel_q + 2'd1;
          if (sel_q == 2'd2) begin
            state_q <= S_ROOT;
            cnt_q   <= '0;
          end else begin
            state_q <= S_SQM;
          end
        end
        S_ROOT: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd31) begin
            state_q <= S_DIVI;
            sel_q   <= '0;
          end
        end
        S_DIVI: begin
          state_q <= S_DIVS;
          cnt_q   <= 6'd14;
        end
        S_DIVS: begin
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd0) begin
            sel_q <= (sel_q == 2'd2) ? 2'd0 : sel_q + 2'd1;
            state_q <= (sel_q == 2'd2) ? S_URD : S_DIVI;
          end
        end
        S_URD: state_q <= S_UWR;
        S_UWR: begin
          sel_q   <= sel_q + 2'd1;
          state_q <= (sel_q == 2'd2) ? S_DONE : S_URD;
        end
        S_DONE: begin
          if (out_free) begin
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_q    <= in_i.command;
          raw_q[0] <= in_i.corner_a;
          raw_q[1] <= in_i.corner_b;
          raw_q[2] <= in_i.corner_c;
          pos_q[0] <= {in_i.pos_z, in_i.pos_y, in_i.pos_x};
          rx_q     <= '0;
          ry_q     <= '0;
          rz_q     <= '0;
          rst_q    <= vna_pkg::StOk;
        end
      end
      S_MOD: begin
        for (int k = 0; k < 3; k++) begin
          quot_q[k] <= CW'(rprod[k] >> QSH);
        end
      end
      S_MODR: begin
        for (int k = 0; k < 3; k++) begin
          raw_q[k] <= raw_q[k] - CW'(MW'(quot_q[k]) * MW'(VERTEX_DEPTH));
        end
      end
      S_SRD: begin
        rx_q <= sum_rdata[19:0];
        ry_q <= sum_rdata[39:20];
        rz_q <= sum_rdata[59:40];
      end
      S_PRD: begin
        case (cnt_q[1:0])
          2'd1:    pos_q[0] <= pos_rdata;
          2'd2:    pos_q[1] <= pos_rdata;
          2'd3:    pos_q[2] <= pos_rdata;
          default: ;
        endcase
      end
      S_EDGE: begin
        for (int k = 0; k < 3; k++) begin
          e1_q[k] <= 25'(signed'(pos_q[1][24*k +: 24])) - 25'(signed'(pos_q[0][24*k +: 24]));
          e2_q[k] <= 25'(signed'(pos_q[2][24*k +: 24])) - 25'(signed'(pos_q[0][24*k +: 24]));
        end
      end
      S_XMUL: prod_q <= opa * opb;
      S_XACC: begin
        if (!cnt_q[0]) begin
          cr_q[cnt_q[2:1]] <= 51'(prod_q);
        end else begin
          cr_q[cnt_q[2:1]] <= cr_q[cnt_q[2:1]] - 51'(prod_q);
        end
      end
      S_ABS: begin
        for (int k = 0; k < 3; k++) begin
          neg_q[k] <= cr_q[k][50];
          mag_q[k] <= cr_q[k][50] ? 51'(-cr_q[k]) : 51'(cr_q[k]);
        end
        if ((cr_q[0] == '0) && (cr_q[1] == '0) && (cr_q[2] == '0)) begin
          rst_q <= vna_pkg::StDegenerate;
        end
      end
      S_NORM: begin
        for (int k = 0; k < 3; k++) begin
          if (any_high) begin
            mag_q[k] <= mag_q[k] >> 1;
          end else if (all_low) begin
            mag_q[k] <= mag_q[k] << 1;
          end
        end
        sq_q <= '0;
      end
      S_SQM: sqp_q <= mag_q[sel_q][29:0] * mag_q[sel_q][29:0];
      S_SQA: begin
        sq_q  <= sq_q + 62'(sqp_q);
        n_q   <= sq_q + 62'(sqp_q);
        res_q <= '0;
      end
      S_ROOT: begin
        if ({2'b00, n_q} >= rtst) begin
          n_q   <= n_q - rtst[61:0];
          res_q <= (res_q >> 1) + rbit[62:0];
        end else begin
          res_q <= res_q >> 1;
        end
      end
      S_DIVI: begin
        rem_q <= 47'({mag_q[sel_q][29:0], 14'd0}) + 47'(res_q[31:1]);
        quo_q <= '0;
      end
      S_DIVS: begin
        if (dtake) begin
          rem_q <= rem_q - dsub;
        end
        quo_q <= quo_nx;
        if (cnt_q == 6'd0) begin
          nrm_q[sel_q] <= neg_q[sel_q] ? -16'(quo_nx) : 16'(quo_nx);
        end
      end
      S_UWR: begin
        if (upd_sat[0] || upd_sat[1] || upd_sat[2]) begin
          rst_q <= vna_pkg::StSaturated;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ox_q  <= rx_q;
          oy_q  <= ry_q;
          oz_q  <= rz_q;
          ost_q <= rst_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid  = ovalid_q;
  assign out_o.sum_x  = ox_q;
  assign out_o.sum_y  = oy_q;
  assign out_o.sum_z  = oz_q;
  assign out_o.status = ost_q;

endmodule

/* tb/vertex_normal_accumulator_test.sv */
`timescale 1ns / 1ps

module vertex_normal_accumulator_test;

  localparam int Depth     = vna_pkg::VertexDepthDefault;
  localparam int IdleLimit = 5000;
  localparam int SumMax    = 524287;
  localparam int SumMin    = -524288;
  localparam int UnitOne   = 16384;

  typedef struct packed {
    logic        [vna_pkg::CmdW-1:0]    cmd;
    logic        [vna_pkg::CornerW-1:0] a;
    logic        [vna_pkg::CornerW-1:0] b;
    logic        [vna_pkg::CornerW-1:0] c;
    logic signed [vna_pkg::PosW-1:0]    px;
    logic signed [vna_pkg::PosW-1:0]    py;
    logic signed [vna_pkg::PosW-1:0]    pz;
  } vertex_cmd_t;

  typedef struct packed {
    logic signed [vna_pkg::SumW-1:0]  x;
    logic signed [vna_pkg::SumW-1:0]  y;
    logic signed [vna_pkg::SumW-1:0]  z;
    logic        [vna_pkg::StatW-1:0] st;
  } normal_result_t;

  logic clk_i;
  logic rst_ni;

  vna_in_if  in_if ();
  vna_out_if out_if ();

  vertex_normal_accumulator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  vertex_cmd_t    pending_cmds[$];
  normal_result_t expected_sums[$];
  int             vert_pos[Depth][3];
  int             vert_sum[Depth][3];
  int             errors;
  int             idle_cycles;
  vertex_cmd_t    drv_cmd;
  int             burst_left;
  int             gap_left;
  logic [7:0]     stall_cnt;
  int             stall_mode;

  task automatic add_cmd(vertex_cmd_t it);
    pending_cmds.insert(pending_cmds.size(), it);
  endtask

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic normal_result_t apply_cmd(vertex_cmd_t it);
    longint          e1[3], e2[3], cr[3];
    longint unsigned mag[3], m, sq, r, q;
    int              nrm[3], idx[3];
    int              up, down, k, j, s;
    bit              sat;
    normal_result_t  res;
    res = '0;
    idx[0] = it.a % Depth;
    idx[1] = it.b % Depth;
    idx[2] = it.c % Depth;
    case (it.cmd)
      vna_pkg::CmdWrite: begin
        vert_pos[idx[0]][0] = int'(it.px);
        vert_pos[idx[0]][1] = int'(it.py);
        vert_pos[idx[0]][2] = int'(it.pz);
        for (k = 0; k < 3; k++) vert_sum[idx[0]][k] = 0;
      end
      vna_pkg::CmdTriangle: begin
        for (k = 0; k < 3; k++) begin
          e1[k] = longint'(vert_pos[idx[1]][k]) - vert_pos[idx[0]][k];
          e2[k] = longint'(vert_pos[idx[2]][k]) - vert_pos[idx[0]][k];
        end
        cr[0] = e1[1] * e2[2] - e2[1] * e1[2];
        cr[1] = e2[0] * e1[2] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e2[0] * e1[1];
        m = 0;
        for (k = 0; k < 3; k++) begin
          mag[k] = cr[k] < 0 ? longint'(-cr[k]) : longint'(cr[k]);
          if (mag[k] > m) m = mag[k];
        end
        if (m == 0) begin
          res.st = vna_pkg::StDegenerate;
        end else begin
          down = 0;
          up   = 0;
          sq   = 0;
          sat  = 0;
          while ((m >> down) >= (64'd1 << 30)) down++;
          while ((m << up) < (64'd1 << 29)) up++;
          for (k = 0; k < 3; k++) begin
            mag[k] = (mag[k] >> down) << up;
            sq += mag[k] * mag[k];
          end
          r = root_floor(sq);
          for (k = 0; k < 3; k++) begin
            q      = (mag[k] * UnitOne + (r >> 1)) / r;
            nrm[k] = cr[k] < 0 ? -int'(q) : int'(q);
          end
          for (j = 0; j < 3; j++) begin
            for (k = 0; k < 3; k++) begin
              s = vert_sum[idx[j]][k] + nrm[k];
              if (s > SumMax) begin
                s   = SumMax;
                sat = 1;
              end else if (s < SumMin) begin
                s   = SumMin;
                sat = 1;
              end
              vert_sum[idx[j]][k] = s;
            end
          end
          res.st = sat ? vna_pkg::StSaturated : vna_pkg::StOk;
        end
      end
      vna_pkg::CmdRead: begin
        res.x = vna_pkg::SumW'(vert_sum[idx[0]][0]);
        res.y = vna_pkg::SumW'(vert_sum[idx[0]][1]);
        res.z = vna_pkg::SumW'(vert_sum[idx[0]][2]);
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic signed [vna_pkg::PosW-1:0] rand_coord();
    logic [31:0] raw;
    raw = $urandom;
    if ($urandom_range(1)) return raw[vna_pkg::PosW-1:0];
    return vna_pkg::PosW'(int'($urandom_range(200)) - 100);
  endfunction

  function automatic vertex_cmd_t rand_cmd(logic [vna_pkg::CmdW-1:0] op);
    vertex_cmd_t it;
    logic [31:0] r1, r2;
    r1 = $urandom;
    r2 = $urandom;
    it.cmd = op;
    it.a   = r1[12:0];
    it.b   = r1[25:13];
    it.c   = r2[12:0];
    it.px  = rand_coord();
    it.py  = rand_coord();
    it.pz  = rand_coord();
    return it;
  endfunction

  function automatic vertex_cmd_t make_write(int addr, int x, int y, int z);
    vertex_cmd_t it;
    it    = rand_cmd(vna_pkg::CmdWrite);
    it.a  = vna_pkg::CornerW'(addr);
    it.px = vna_pkg::PosW'(x);
    it.py = vna_pkg::PosW'(y);
    it.pz = vna_pkg::PosW'(z);
    return it;
  endfunction

  function automatic vertex_cmd_t make_tri(int va, int vb, int vc);
    vertex_cmd_t it;
    it   = rand_cmd(vna_pkg::CmdTriangle);
    it.a = vna_pkg::CornerW'(va);
    it.b = vna_pkg::CornerW'(vb);
    it.c = vna_pkg::CornerW'(vc);
    return it;
  endfunction

  function automatic vertex_cmd_t make_read(int addr);
    vertex_cmd_t it;
    it   = rand_cmd(vna_pkg::CmdRead);
    it.a = vna_pkg::CornerW'(addr);
    return it;
  endfunction

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    vertex_cmd_t nx;
    bit          take;
    if (!rst_ni) begin
      in_if.valid    <= 1'b0;
      in_if.command  <= '0;
      in_if.corner_a <= '0;
      in_if.corner_b <= '0;
      in_if.corner_c <= '0;
      in_if.pos_x    <= '0;
      in_if.pos_y    <= '0;
      in_if.pos_z    <= '0;
      burst_left     <= 1;
      gap_left       <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_sums.insert(expected_sums.size(), apply_cmd(drv_cmd));
      end
      if (!in_if.valid || in_if.ready) begin
        take = 0;
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_cmds.size() > 0) begin
          take = 1;
          nx   = pending_cmds.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(30, 1);
            gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
        in_if.valid <= take;
        if (take) begin
          drv_cmd        <= nx;
          in_if.command  <= nx.cmd;
          in_if.corner_a <= nx.a;
          in_if.corner_b <= nx.b;
          in_if.corner_c <= nx.c;
          in_if.pos_x    <= nx.px;
          in_if.pos_y    <= nx.py;
          in_if.pos_z    <= nx.pz;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_cnt    <= '0;
      stall_mode   <= 0;
    end else begin
      stall_cnt <= stall_cnt + 8'd1;
      if (stall_cnt == 0) stall_mode <= $urandom_range(2);
      out_if.ready <= (stall_mode == 0) ? 1'b1 :
                      (stall_mode == 1) ? 1'($urandom_range(1)) :
                      ($urandom_range(7) == 0);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    normal_result_t act, exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      act = {out_if.sum_x, out_if.sum_y, out_if.sum_z, out_if.status};
      if (expected_sums.size() == 0) begin
        $display("%0t unexpected item: sum %0d %0d %0d status %0d", $time,
                 act.x, act.y, act.z, act.st);
        errors++;
      end else begin
        exp_r = expected_sums.pop_front();
        if (act.x !== exp_r.x || act.y !== exp_r.y || act.z !== exp_r.z ||
            act.st !== exp_r.st) begin
          $display("%0t mismatch: expected sum %0d %0d %0d status %0d, got %0d %0d %0d status %0d",
                   $time, exp_r.x, exp_r.y, exp_r.z, exp_r.st, act.x, act.y, act.z, act.st);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("[vertex_normal_accumulator] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          pool[$];
    int          count, r, va, vb, vc, reps, k;
    vertex_cmd_t it;
    errors      = 0;
    idle_cycles = 0;
    rst_ni      = 1'b0;

    // directed: extremes, all commands, degenerate and collinear triangles
    add_cmd(make_write(0, 8388607, 8388607, 8388607));
    add_cmd(make_write(8191, -8388608, -8388608, -8388608));
    add_cmd(make_write(4096, 8388607, -8388608, 0));
    add_cmd(make_write(1, 0, 0, 0));
    add_cmd(make_write(2, 256, 0, 0));
    add_cmd(make_write(3, 0, 256, 0));
    add_cmd(make_write(4, 512, 0, 0));
    add_cmd(make_tri(1, 2, 3));
    add_cmd(make_tri(1, 2, 4));
    add_cmd(make_tri(1, 1, 2));
    add_cmd(make_tri(0, 8191, 4096));
    add_cmd(make_tri(3, 2, 1));
    add_cmd(make_tri(8191, 0, 4096));
    add_cmd(make_read(1));
    add_cmd(make_read(2));
    add_cmd(make_read(0));
    add_cmd(make_read(8191));
    it = rand_cmd(vna_pkg::CmdUnused);
    it.a = '1; it.b = '1; it.c = '1;
    add_cmd(it);
    add_cmd(make_read(4096));
    pool = '{0, 8191, 4096, 1, 2, 3, 4};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // hold off until the directed part has fully drained
    wait (pending_cmds.size() == 0 && !in_if.valid && expected_sums.size() == 0);

    count = 0;
    while (count < 1300) begin
      r = $urandom_range(99);
      if (r < 12) begin
        it = rand_cmd(vna_pkg::CmdWrite);
        if ($urandom_range(9) < 3) it.a = vna_pkg::CornerW'(pool[$urandom_range(pool.size() - 1)]);
        else if (pool.size() < 24) pool.insert(pool.size(), int'(it.a));
        else pool[$urandom_range(pool.size() - 1)] = int'(it.a);
        add_cmd(it);
        count++;
      end else if (r < 68) begin
        va = pool[$urandom_range(pool.size() - 1)];
        vb = pool[$urandom_range(pool.size() - 1)];
        vc = ($urandom_range(9) == 0) ? va : pool[$urandom_range(pool.size() - 1)];
        add_cmd(make_tri(va, vb, vc));
        count++;
      end else if (r < 72) begin
        // same triangle over and over to drive the sums into saturation
        va   = pool[$urandom_range(pool.size() - 1)];
        vb   = pool[$urandom_range(pool.size() - 1)];
        vc   = pool[$urandom_range(pool.size() - 1)];
        reps = $urandom_range(45, 20);
        for (k = 0; k < reps; k++) add_cmd(make_tri(va, vb, vc));
        add_cmd(make_read(va));
        add_cmd(make_read(vc));
        count += reps + 2;
      end else if (r < 95) begin
        add_cmd(make_read(pool[$urandom_range(pool.size() - 1)]));
        count++;
      end else begin
        add_cmd(rand_cmd(vna_pkg::CmdUnused));
        count++;
      end
    end

    wait (pending_cmds.size() == 0 && !in_if.valid);
    wait (expected_sums.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_sums.size() == 0) begin
      $display("[vertex_normal_accumulator] OK");
    end else begin
      $display("[vertex_normal_accumulator] ERROR");
    end
    $finish;
  end

endmodule
